// ===== hdl/sega_pkg.sv =====
// package for the segment allocator: constants, codes and state type
// no dependencies
`default_nettype none
package sega_pkg;
    localparam int MapDepth = 16;
    localparam int AddrBits = 16;

    localparam logic [1:0] OpAlloc   = 2'd0;
    localparam logic [1:0] OpRelease = 2'd1;
    localparam logic [1:0] OpClear   = 2'd2;
    localparam logic [1:0] OpUnknown = 2'd3;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StNoFit    = 2'd1;
    localparam logic [1:0] StNotFound = 2'd2;
    localparam logic [1:0] StFull     = 2'd3;

    localparam logic [1:0] PolFirst = 2'd0;
    localparam logic [1:0] PolBest  = 2'd1;
    localparam logic [1:0] PolWorst = 2'd2;
    localparam logic [1:0] PolNext  = 2'd3;

    localparam logic RegPolicy = 1'b0;
    localparam logic RegMemSize = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_UP,
        S_SPLIT,
        S_REL_NEXT,
        S_REL_PREV,
        S_SHIFT_DN,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/segment_allocator_unit.sv =====
// segment allocator top level: segment table, scan/shift sequencer, apb registers
// depends on sega_pkg
`default_nettype none
// An item is taken whenever the sequencer is idle. An allocate scans up to MAP_DEPTH entries
// one per cycle through a single size compare; on a split it then moves the tail of the
// table up one entry at a time (read, then write). A release scans for the match and,
// for each merge, moves the tail down one entry a cycle. The worst case is an allocate that
// splits entry 0 of a table holding MAP_DEPTH-1 entries; a clear skips the scan and goes
// from the decide step straight to done. The result sits in its own output register,
// so the next item is taken while it waits; a finished item holds in its last step until
// that register is free. The table is undefined until a clear.
module segment_allocator_unit #(
    parameter int MAP_DEPTH = sega_pkg::MapDepth,
    parameter int ADDR_BITS = sega_pkg::AddrBits
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [1:0]                       i_operation,
    input  wire logic [ADDR_BITS:0]               i_request_size,
    input  wire logic [7:0]                       i_owner_id,
    input  wire logic [ADDR_BITS-1:0]             i_block_start,
    input  wire logic [ADDR_BITS-1:0]             i_block_end,
    input  wire logic [$clog2(MAP_DEPTH)-1:0]     i_search_start,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [1:0]                            o_status,
    output logic [ADDR_BITS-1:0]                  o_alloc_start,
    output logic [ADDR_BITS-1:0]                  o_alloc_end,
    output logic [ADDR_BITS:0]                    o_alloc_size,
    output logic [7:0]                            o_alloc_owner,
    output logic [$clog2(MAP_DEPTH + 1)-1:0]      o_segment_total
);
    localparam int IW = $clog2(MAP_DEPTH);
    localparam int CW = $clog2(MAP_DEPTH + 1);
    localparam int AW = ADDR_BITS;

    // table memory: start, end, owner
    logic [AW-1:0] r_tstart [MAP_DEPTH];
    logic [AW-1:0] r_tend   [MAP_DEPTH];
    logic [7:0]    r_towner [MAP_DEPTH];

    sega_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_policy;
    logic [AW:0]   r_memsize;

    logic [1:0]    r_op;
    logic [AW:0]   r_req;
    logic [7:0]    r_own;
    logic [AW-1:0] r_bs, r_be;

    logic [CW-1:0] r_k, n_k;        // scan step / shift pointer
    logic [IW-1:0] r_i, n_i;        // current index
    logic          r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;
    logic [AW:0]   r_best, n_best;

    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_st, n_st;
    logic [AW-1:0] r_as, n_as, r_ae, n_ae;
    logic [AW:0]   r_az, n_az;
    logic [7:0]    r_ao, n_ao;

    // result register, loaded when a finished item hands over its result
    logic          out_load;
    logic [1:0]    r_out_status;
    logic [AW-1:0] r_out_start, r_out_end;
    logic [AW:0]   r_out_size;
    logic [7:0]    r_out_owner;
    logic [CW-1:0] r_out_total;

    // table write port
    logic          w_en;
    logic [IW-1:0] w_idx;
    logic [AW-1:0] w_start, w_end;
    logic [7:0]    w_owner;

    // shared read and compare unit
    logic [AW-1:0] rd_start, rd_end;
    logic [7:0]    rd_owner;
    logic [AW:0]   rd_size;
    logic [IW-1:0] nxt_i;
    logic          cand;
    logic          cw_wr;

    assign pready = 1'b1;
    assign cw_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == sega_pkg::RegPolicy) begin
            prdata[1:0] = r_policy;
        end else begin
            prdata[AW:0] = r_memsize;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= sega_pkg::PolFirst;
            r_memsize <= (AW+1)'(1) << AW;
        end else if (cw_wr) begin
            if (paddr[2] == sega_pkg::RegPolicy) begin
                r_policy <= pwdata[1:0];
            end else begin
                r_memsize <= pwdata[AW:0];
            end
        end
    end

    assign rd_start = r_tstart[r_i];
    assign rd_end   = r_tend[r_i];
    assign rd_owner = r_towner[r_i];
    assign rd_size  = {1'b0, rd_end} - {1'b0, rd_start} + (AW+1)'(1);
    assign cand     = (rd_owner == 8'd0) && (rd_size >= r_req);
    // next index, wrapping to 0 at the end of the table for every policy
    assign nxt_i    = ({1'b0, r_i} + 1'b1 >= {1'b0, r_count[IW-1:0]} && r_count != CW'(MAP_DEPTH)
                       || {1'b0, r_i} + 1'b1 >= (IW+1)'(r_count)) ? '0 : r_i + 1'b1;

    assign out_load        = (r_state == sega_pkg::S_DONE) && (!r_ovalid || i_ready);
    assign o_ready         = (r_state == sega_pkg::S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_out_status;
    assign o_alloc_start   = r_out_start;
    assign o_alloc_end     = r_out_end;
    assign o_alloc_size    = r_out_size;
    assign o_alloc_owner   = r_out_owner;
    assign o_segment_total = r_out_total;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tstart[w_idx] <= w_start;
            r_tend[w_idx]   <= w_end;
            r_towner[w_idx] <= w_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sega_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_st;
            r_out_start  <= r_as;
            r_out_end    <= r_ae;
            r_out_size   <= r_az;
            r_out_owner  <= r_ao;
            r_out_total  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_i <= n_i; r_found <= n_found; r_pick <= n_pick; r_best <= n_best;
        r_st <= n_st; r_as <= n_as; r_ae <= n_ae; r_az <= n_az; r_ao <= n_ao;
        if (i_valid && o_ready) begin
            r_op   <= i_operation;
            r_req  <= i_request_size;
            r_own  <= i_owner_id;
            r_bs   <= i_block_start;
            r_be   <= i_block_end;
        end
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_ovalid = r_ovalid;
        n_k = r_k; n_i = r_i; n_found = r_found; n_pick = r_pick; n_best = r_best;
        n_st = r_st; n_as = r_as; n_ae = r_ae; n_az = r_az; n_ao = r_ao;
        w_en = 1'b0; w_idx = r_i; w_start = rd_start; w_end = rd_end; w_owner = rd_owner;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            sega_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_st = sega_pkg::StOk;
                    n_as = '0; n_ae = '0; n_az = '0; n_ao = '0;
                    n_k = '0; n_found = 1'b0; n_pick = '0; n_best = '0;
                    n_i = (i_operation == sega_pkg::OpAlloc && r_policy == sega_pkg::PolNext
                           && {1'b0, i_search_start} < (IW+1)'(r_count)) ? i_search_start : '0;
                    n_state = sega_pkg::S_SCAN;
                    if (i_operation == sega_pkg::OpAlloc) begin
                        if (i_request_size == '0 || i_owner_id == 8'd0) begin
                            n_k = r_count;   // skip scan, report no fit
                        end
                    end else if (i_operation == sega_pkg::OpRelease) begin
                        if (i_owner_id == 8'd0) n_k = r_count;
                    end else begin
                        n_state = sega_pkg::S_DECIDE;
                    end
                end
            end
            sega_pkg::S_SCAN: begin
                if (r_k >= r_count || (r_found && r_op == sega_pkg::OpAlloc &&
                    (r_policy == sega_pkg::PolFirst || r_policy == sega_pkg::PolNext))
                    || (r_found && r_op == sega_pkg::OpRelease)) begin
                    n_state = sega_pkg::S_DECIDE;
                    n_i = r_pick;
                end else begin
                    n_k = r_k + 1'b1;
                    n_i = nxt_i;
                    if (r_op == sega_pkg::OpAlloc) begin
                        if (cand && (!r_found ||
                            (r_policy == sega_pkg::PolBest && rd_size < r_best) ||
                            (r_policy == sega_pkg::PolWorst && rd_size > r_best))) begin
                            n_found = 1'b1; n_pick = r_i; n_best = rd_size;
                        end
                    end else if (rd_start == r_bs && rd_end == r_be && rd_owner == r_own) begin
                        n_found = 1'b1; n_pick = r_i;
                    end
                end
            end
            sega_pkg::S_DECIDE: begin
                n_state = sega_pkg::S_DONE;
                if (r_op == sega_pkg::OpAlloc) begin
                    if (!r_found) begin
                        n_st = sega_pkg::StNoFit;
                    end else if (r_best > r_req && r_count >= CW'(MAP_DEPTH)) begin
                        n_st = sega_pkg::StFull;
                    end else if (r_best > r_req) begin
                        n_k = r_count;
                        n_state = sega_pkg::S_SHIFT_UP;
                    end else begin
                        w_en = 1'b1; w_owner = r_own;
                        n_as = rd_start; n_ae = rd_end; n_az = r_req; n_ao = r_own;
                    end
                end else if (r_op == sega_pkg::OpRelease) begin
                    if (!r_found) begin
                        n_st = sega_pkg::StNotFound;
                    end else begin
                        w_en = 1'b1; w_owner = 8'd0;
                        n_state = sega_pkg::S_REL_NEXT;
                        n_i = r_pick + 1'b1;
                    end
                end else if (r_op == sega_pkg::OpClear) begin
                    w_en = 1'b1; w_idx = '0; w_start = '0; w_owner = 8'd0;
                    w_end = (r_memsize == '0) ? '0
                          : (r_memsize > ((AW+1)'(1) << AW)) ? '1 : AW'(r_memsize - 1'b1);
                    n_count = CW'(1);
                end
            end
            sega_pkg::S_SHIFT_UP: begin
                // copy entry k-1 to k, walking down to the split point
                if (r_k > CW'(r_pick) + 1'b1) begin
                    n_i = IW'(r_k - 1'b1);
                    n_k = r_k - 1'b1;
                    n_state = sega_pkg::S_SHIFT_UP;
                    if (r_i == IW'(r_k - 1'b1)) begin
                        w_en = 1'b1; w_idx = IW'(r_k);
                    end else begin
                        n_k = r_k;
                    end
                end else begin
                    n_i = r_pick;
                    if (r_i == r_pick) begin
                        w_en = 1'b1; w_idx = r_pick + 1'b1;
                        w_start = rd_start + AW'(r_req); w_owner = 8'd0;
                        n_state = sega_pkg::S_SPLIT;
                    end
                end
            end
            sega_pkg::S_SPLIT: begin
                w_en = 1'b1; w_end = rd_start + AW'(r_req) - 1'b1; w_owner = r_own;
                n_as = rd_start; n_ae = w_end; n_az = r_req; n_ao = r_own;
                n_count = r_count + 1'b1;
                n_state = sega_pkg::S_DONE;
            end
            sega_pkg::S_REL_NEXT: begin
                // r_i points at the right neighbour
                if (CW'(r_pick) + 1'b1 < r_count && rd_owner == 8'd0) begin
                    w_en = 1'b1; w_idx = r_pick; w_start = r_bs; w_owner = 8'd0;
                    n_k = CW'(r_pick) + 1'b1;
                    n_i = r_pick + 1'b1;
                    n_found = 1'b0;   // clear found so the shift-down goes on to the left neighbour
                    n_state = sega_pkg::S_SHIFT_DN;
                end else begin
                    n_found = 1'b0;
                    n_i = r_pick - 1'b1;
                    n_state = sega_pkg::S_REL_PREV;
                end
            end
            sega_pkg::S_REL_PREV: begin
                if (r_pick != '0 && rd_owner == 8'd0) begin
                    // left neighbour absorbs released entry
                    n_i = r_pick;
                    if (r_i == r_pick) begin
                        n_found = 1'b1;
                        n_best = {1'b0, rd_end};
                        n_i = r_pick - 1'b1;
                    end else if (r_found) begin
                        w_en = 1'b1; w_end = r_best[AW-1:0];
                        n_k = CW'(r_pick);
                        n_i = r_pick;
                        n_pick = '1;   // no further left merge
                        n_state = sega_pkg::S_SHIFT_DN;
                    end
                end else begin
                    n_state = sega_pkg::S_DONE;
                end
            end
            sega_pkg::S_SHIFT_DN: begin
                // remove entry k: copy each later entry down by one, after reading entry k+1
                if (r_k + 1'b1 < r_count) begin
                    if (r_i == IW'(r_k + 1'b1)) begin
                        w_en = 1'b1; w_idx = IW'(r_k);
                        n_k = r_k + 1'b1;
                        n_i = IW'(r_k + 2'd2);
                    end else begin
                        n_i = IW'(r_k + 1'b1);
                    end
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_pick == '1 && r_found) begin
                        n_state = sega_pkg::S_DONE;
                    end else begin
                        n_found = 1'b0;
                        n_i = r_pick - 1'b1;
                        n_state = (r_pick == '0) ? sega_pkg::S_DONE : sega_pkg::S_REL_PREV;
                    end
                end
            end
            sega_pkg::S_DONE: begin
                // hold until the result register is free
                if (out_load) begin
                    n_ovalid = 1'b1;
                    n_state = sega_pkg::S_IDLE;
                end
            end
            default: n_state = sega_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
